// ===== rtl/lca_pkg.sv =====
package lca_pkg;

  localparam int unsigned NodesDef  = 1024;
  localparam int unsigned LevelsDef = 10;
  localparam int unsigned NodeW     = 10;
  localparam int unsigned EpochW    = 8;

  typedef logic [NodeW-1:0] node_t;
  typedef logic [NodeW-1:0] depth_t;
  typedef logic [EpochW-1:0] epoch_t;

  localparam depth_t DepthMax = '1;
  localparam depth_t LenMax   = '1;

  localparam logic [1:0] FN_ATTACH = 2'd0;
  localparam logic [1:0] FN_QUERY  = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PARENT = 2'd1;
  localparam logic [1:0] ST_NO_NODE   = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    node_t      node_a;
    node_t      node_b;
    node_t      parent_node;
    logic       is_root;
  } req_t;

  typedef struct packed {
    node_t      ancestor_node;
    depth_t     path_length;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic  rd;
    node_t rd_node;
    logic  wr;
    node_t wr_node;
    logic  clr;
  } mark_req_t;

  function automatic logic node_in_range(input node_t v, input int unsigned lim);
    return 32'(v) < lim;
  endfunction

endpackage

// ===== rtl/lca_mark.sv =====
module lca_mark #(
  parameter int unsigned NODES = lca_pkg::NodesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lca_pkg::mark_req_t  req_i,
  output logic                hit_o,
  output logic                busy_o
);

  localparam int unsigned AW = $clog2(NODES);

  lca_pkg::epoch_t mark_mem [NODES];

  lca_pkg::epoch_t epoch_q;
  logic            pass_q;
  logic [AW-1:0]   cnt_q;
  lca_pkg::epoch_t rd_q;
  logic            rng_q;

  // epoch tagging; a sweep rewrites every entry after reset and on epoch wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= lca_pkg::epoch_t'(1);
      pass_q  <= 1'b1;
      cnt_q   <= '0;
    end else begin
      if (pass_q) begin
        if (cnt_q == AW'(NODES - 1)) begin
          pass_q <= 1'b0;
          cnt_q  <= '0;
        end else begin
          cnt_q <= cnt_q + AW'(1);
        end
      end else if (req_i.clr) begin
        if (epoch_q == '1) begin
          epoch_q <= lca_pkg::epoch_t'(1);
          pass_q  <= 1'b1;
        end else begin
          epoch_q <= epoch_q + lca_pkg::epoch_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pass_q) begin
      mark_mem[cnt_q] <= '0;
    end else if (req_i.wr && lca_pkg::node_in_range(req_i.wr_node, NODES)) begin
      mark_mem[AW'(req_i.wr_node)] <= epoch_q;
    end
  end

  // registered read; the epoch does not move between a read and its use
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_q  <= mark_mem[AW'(req_i.rd_node)];
      rng_q <= lca_pkg::node_in_range(req_i.rd_node, NODES);
    end
  end

  assign hit_o  = rng_q && (rd_q == epoch_q);
  assign busy_o = pass_q;

endmodule

// ===== rtl/lowest_common_ancestor_engine.sv =====
// Binary-lifting ancestor table for a rooted forest of up to NODES nodes, LEVELS
// jump levels. One request at a time, one result per request. Depths and jump
// entries sit in single-write memories (the jump table has two read ports), so
// cost is set by one registered table read per step: a root attach writes each
// jump level in turn, a child attach reads its parent and then each level, a
// query lifts the deeper node and then jumps both nodes level by level, and a
// clear steps the epoch. The attached marks are epoch-tagged; after reset and
// after every 255th clear a sweep rewrites them; no request is taken meanwhile.
module lowest_common_ancestor_engine #(
  parameter int unsigned NODES  = lca_pkg::NodesDef,
  parameter int unsigned LEVELS = lca_pkg::LevelsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lca_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lca_pkg::rsp_t out_data_o
);

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned NodeWp1 = lca_pkg::NodeW + 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_RWR   = 5'd2;
  localparam logic [4:0] S_AP    = 5'd3;
  localparam logic [4:0] S_AL    = 5'd4;
  localparam logic [4:0] S_AW    = 5'd5;
  localparam logic [4:0] S_QA    = 5'd6;
  localparam logic [4:0] S_QB    = 5'd7;
  localparam logic [4:0] S_LIFT  = 5'd8;
  localparam logic [4:0] S_LJ    = 5'd9;
  localparam logic [4:0] S_LD    = 5'd10;
  localparam logic [4:0] S_CMP   = 5'd11;
  localparam logic [4:0] S_JI    = 5'd12;
  localparam logic [4:0] S_JW    = 5'd13;
  localparam logic [4:0] S_ANC   = 5'd14;
  localparam logic [4:0] S_AN2   = 5'd15;
  localparam logic [4:0] S_DIST  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]          state_q, state_d;
  lca_pkg::req_t       item_q, item_d;
  lca_pkg::node_t      x_q, x_d, y_q, y_d, anc_q, anc_d;
  lca_pkg::depth_t     dx_q, dx_d, dy_q, dy_d, da_q, da_d, db_q, db_d, len_q, len_d;
  logic [LW-1:0]       lvl_q, lvl_d;
  logic                aok_q, aok_d;
  logic [1:0]          st_q, st_d;
  logic                out_valid_q;
  lca_pkg::rsp_t       out_q;

  lca_pkg::depth_t     dep_mem [NODES];
  lca_pkg::node_t      jmp_mem [LEVELS][NODES];

  logic                dep_we;
  lca_pkg::node_t      dep_wnode, dep_rnode;
  lca_pkg::depth_t     dep_wdata, dep_rdata_q;
  logic                jmp_we;
  logic [LW-1:0]       jmp_wlvl, jmpa_lvl;
  lca_pkg::node_t      jmp_wnode, jmp_wdata, jmpa_q, jmpb_q;

  lca_pkg::mark_req_t  mark_req;
  logic                mark_hit, mark_busy;

  logic [NodeWp1-1:0]  gap;
  logic [16:0]         step;
  logic                lift;
  lca_pkg::depth_t     dsat;
  logic signed [12:0]  len_raw;
  logic                out_free;

  lca_mark #(
    .NODES(NODES)
  ) u_mark (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mark_req),
    .hit_o  (mark_hit),
    .busy_o (mark_busy)
  );

  assign gap   = {1'b0, dx_q} - {1'b0, dy_q};
  assign step  = 17'(1) << lvl_q;
  assign lift  = !gap[lca_pkg::NodeW] && (17'(gap[lca_pkg::NodeW-1:0]) >= step);
  assign dsat  = (dep_rdata_q == lca_pkg::DepthMax) ? dep_rdata_q
                                                    : dep_rdata_q + lca_pkg::depth_t'(1);
  assign len_raw = $signed(13'(da_q)) + $signed(13'(db_q))
                 - $signed({2'b00, dep_rdata_q, 1'b0});
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    x_d       = x_q;
    y_d       = y_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    da_d      = da_q;
    db_d      = db_q;
    lvl_d     = lvl_q;
    aok_d     = aok_q;
    st_d      = st_q;
    anc_d     = anc_q;
    len_d     = len_q;
    dep_we    = 1'b0;
    dep_wnode = item_q.node_a;
    dep_wdata = '0;
    dep_rnode = x_q;
    jmp_we    = 1'b0;
    jmp_wlvl  = lvl_q;
    jmp_wnode = item_q.node_a;
    jmp_wdata = item_q.node_a;
    jmpa_lvl  = lvl_q;
    mark_req  = '0;
    mark_req.wr_node = item_q.node_a;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !mark_busy) begin
          item_d  = in_data_i;
          state_d = S_START;
        end
      end
      S_START: begin
        st_d  = lca_pkg::ST_OK;
        anc_d = '0;
        len_d = '0;
        lvl_d = '0;
        case (item_q.func)
          lca_pkg::FN_ATTACH: begin
            if (item_q.is_root) begin
              state_d = lca_pkg::node_in_range(item_q.node_a, NODES) ? S_RWR : S_DONE;
            end else begin
              mark_req.rd      = 1'b1;
              mark_req.rd_node = item_q.parent_node;
              dep_rnode        = item_q.parent_node;
              state_d          = S_AP;
            end
          end
          lca_pkg::FN_QUERY: begin
            mark_req.rd      = 1'b1;
            mark_req.rd_node = item_q.node_a;
            dep_rnode        = item_q.node_a;
            state_d          = S_QA;
          end
          lca_pkg::FN_CLEAR: begin
            mark_req.clr = 1'b1;
            state_d      = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RWR: begin
        dep_we = 1'b1;
        jmp_we = 1'b1;
        if (lvl_q == LW'(LEVELS - 1)) begin
          mark_req.wr = 1'b1;
          state_d     = S_DONE;
        end else begin
          lvl_d = lvl_q + LW'(1);
        end
      end
      S_AP: begin
        if (!mark_hit) begin
          st_d    = lca_pkg::ST_NO_PARENT;
          state_d = S_DONE;
        end else if (!lca_pkg::node_in_range(item_q.node_a, NODES)) begin
          state_d = S_DONE;
        end else begin
          dep_we    = 1'b1;
          dep_wdata = dsat;
          jmp_we    = 1'b1;
          jmp_wlvl  = '0;
          jmp_wdata = item_q.parent_node;
          x_d       = item_q.parent_node;
          lvl_d     = '0;
          if (LEVELS == 1) begin
            mark_req.wr = 1'b1;
            state_d     = S_DONE;
          end else begin
            state_d = S_AL;
          end
        end
      end
      S_AL: state_d = S_AW;
      S_AW: begin
        jmp_we    = 1'b1;
        jmp_wlvl  = lvl_q + LW'(1);
        jmp_wdata = jmpa_q;
        x_d       = jmpa_q;
        if (lvl_q == LW'(LEVELS - 2)) begin
          mark_req.wr = 1'b1;
          state_d     = S_DONE;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = S_AL;
        end
      end
      S_QA: begin
        aok_d            = mark_hit;
        da_d             = dep_rdata_q;
        mark_req.rd      = 1'b1;
        mark_req.rd_node = item_q.node_b;
        dep_rnode        = item_q.node_b;
        state_d          = S_QB;
      end
      S_QB: begin
        if (!aok_q || !mark_hit) begin
          st_d    = lca_pkg::ST_NO_NODE;
          state_d = S_DONE;
        end else begin
          db_d = dep_rdata_q;
          if (da_q < dep_rdata_q) begin
            x_d  = item_q.node_b;
            dx_d = dep_rdata_q;
            y_d  = item_q.node_a;
            dy_d = da_q;
          end else begin
            x_d  = item_q.node_a;
            dx_d = da_q;
            y_d  = item_q.node_b;
            dy_d = dep_rdata_q;
          end
          lvl_d   = LW'(LEVELS - 1);
          state_d = S_LIFT;
        end
      end
      S_LIFT: begin
        if (lift) begin
          state_d = S_LJ;
        end else if (lvl_q == '0) begin
          state_d = S_CMP;
        end else begin
          lvl_d = lvl_q - LW'(1);
        end
      end
      S_LJ: begin
        x_d       = jmpa_q;
        dep_rnode = jmpa_q;
        state_d   = S_LD;
      end
      S_LD: begin
        dx_d = dep_rdata_q;
        if (lvl_q == '0) begin
          state_d = S_CMP;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = S_LIFT;
        end
      end
      S_CMP: begin
        if (x_q == y_q) begin
          state_d = S_DIST;
        end else begin
          lvl_d   = LW'(LEVELS - 1);
          state_d = S_JI;
        end
      end
      S_JI: state_d = S_JW;
      S_JW: begin
        if (jmpa_q != jmpb_q) begin
          x_d = jmpa_q;
          y_d = jmpb_q;
        end
        if (lvl_q == '0) begin
          state_d = S_ANC;
        end else begin
          lvl_d   = lvl_q - LW'(1);
          state_d = S_JI;
        end
      end
      S_ANC: begin
        jmpa_lvl = '0;
        state_d  = S_AN2;
      end
      S_AN2: begin
        x_d       = jmpa_q;
        dep_rnode = jmpa_q;
        state_d   = S_DIST;
      end
      S_DIST: begin
        anc_d = x_q;
        if (len_raw[12]) begin
          len_d = '0;
        end else if (|len_raw[11:10]) begin
          len_d = lca_pkg::LenMax;
        end else begin
          len_d = len_raw[9:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    x_q    <= x_d;
    y_q    <= y_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    da_q   <= da_d;
    db_q   <= db_d;
    lvl_q  <= lvl_d;
    aok_q  <= aok_d;
    st_q   <= st_d;
    anc_q  <= anc_d;
    len_q  <= len_d;
    if (state_q == S_DONE && out_free) begin
      out_q <= '{ancestor_node: anc_q, path_length: len_q, status: st_q};
    end
  end

  // depth table: one write, one read port; out-of-range nodes read as zero
  always_ff @(posedge clk_i) begin
    if (dep_we) begin
      dep_mem[AW'(dep_wnode)] <= dep_wdata;
    end
    dep_rdata_q <= lca_pkg::node_in_range(dep_rnode, NODES) ? dep_mem[AW'(dep_rnode)] : '0;
  end

  // jump table: one write, two read ports
  always_ff @(posedge clk_i) begin
    if (jmp_we) begin
      jmp_mem[jmp_wlvl][AW'(jmp_wnode)] <= jmp_wdata;
    end
    jmpa_q <= lca_pkg::node_in_range(x_q, NODES) ? jmp_mem[jmpa_lvl][AW'(x_q)] : '0;
    jmpb_q <= lca_pkg::node_in_range(y_q, NODES) ? jmp_mem[lvl_q][AW'(y_q)] : '0;
  end

  assign in_ready_o  = (state_q == S_IDLE) && !mark_busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != lca_pkg::ST_OK
      |-> out_data_o.ancestor_node == '0 && out_data_o.path_length == '0)
    else $error("error result carries ancestor or length");

  a_sweep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_busy |-> !in_ready_o && !dep_we && !jmp_we)
    else $error("table activity during mark sweep");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_START && !in_ready_o)
    else $error("accepted request not started");

endmodule
